// File: design/mmwa_pkg.sv
package mmwa_pkg;

    // Sample and fixed-point formats
    localparam int AXIS_BITS     = 13;
    localparam int FRACTION_BITS = 8;

    // Derived datapath widths
    localparam int DIFF_W   = AXIS_BITS + 1;
    localparam int SQ_W     = 2 * AXIS_BITS + 2;
    localparam int RAD_W    = SQ_W + 2 * FRACTION_BITS;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SUB_W    = REM_W + 2;
    localparam int SUM_W    = 32;
    localparam int COUNT_W  = 8;
    localparam int GAIN_W   = 24;
    localparam int OFFSET_W = 32;
    localparam int VALUE_W  = 32;
    localparam int MUL_A_W  = SUM_W + 1;
    localparam int MUL_B_W  = GAIN_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SHIFT_W  = PROD_W - FRACTION_BITS;
    localparam int TOTAL_W  = SHIFT_W + 1;
    localparam int STEP_W   = $clog2(SUM_W);
    localparam int FUNC_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Square phase: three products, then one more step to fold the last one
    localparam int SQUARE_STEPS = 4;

    // Register reset values
    localparam logic [GAIN_W-1:0]   RESET_GAIN        = GAIN_W'(65536);
    localparam logic [OFFSET_W-1:0] RESET_OFFSET      = '0;
    localparam logic [COUNT_W-1:0]  RESET_MAX_SAMPLES = COUNT_W'(200);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REF  = 2'd0,
        FUNC_ACC  = 2'd1,
        FUNC_TICK = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN        = 2'd0,
        CFG_OFFSET      = 2'd1,
        CFG_MAX_SAMPLES = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_ACC,
        ST_DIV_LOAD,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_REF,
        OP_LOAD_DIFF,
        OP_SQUARE,
        OP_ROOT,
        OP_ACC,
        OP_DIV_LOAD,
        OP_DIV,
        OP_MUL
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [STEP_W-1:0] step;
        logic              out_load;
        logic              out_has_data;
        logic              out_limit;
    } dp_ctrl_t;

    typedef struct packed {
        logic window_open;
        logic count_zero;
        logic limit_hit;
    } dp_stat_t;

endpackage

// File: design/mmwa_if.sv
interface mmwa_sample_if import mmwa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [AXIS_BITS-1:0] accel_x;
    logic [AXIS_BITS-1:0] accel_y;
    logic [AXIS_BITS-1:0] accel_z;

    modport source (output valid, func, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, func, accel_x, accel_y, accel_z, output ready);
endinterface

interface mmwa_result_if import mmwa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  motion_value;
    logic [COUNT_W-1:0]  sample_count;
    logic                has_data;
    logic                closed_by_limit;

    modport source (output valid, motion_value, sample_count, has_data, closed_by_limit,
                    input ready);
    modport sink   (input valid, motion_value, sample_count, has_data, closed_by_limit,
                    output ready);
endinterface

interface mmwa_cfg_if import mmwa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/mmwa_dp.sv
module mmwa_dp import mmwa_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    mmwa_sample_if.sink          sample,
    mmwa_cfg_if.sink             cfg,
    input  dp_ctrl_t             ctrl,
    output dp_stat_t             stat,
    output logic [VALUE_W-1:0]   motion_value,
    output logic [COUNT_W-1:0]   sample_count,
    output logic                 has_data,
    output logic                 closed_by_limit
);

    // Configuration
    logic [GAIN_W-1:0]   gain_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [COUNT_W-1:0]  max_reg;

    // Window state
    logic [AXIS_BITS-1:0] ref_x_reg, ref_y_reg, ref_z_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 open_reg;

    // Working registers
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [SUM_W-1:0]         q_reg;
    logic [COUNT_W-1:0]       drem_reg;

    // Result register
    logic [VALUE_W-1:0] value_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_has_reg;
    logic               out_limit_reg;

    // Combinational nets
    logic signed [DIFF_W-1:0]  new_dx, new_dy, new_dz, sq_sel;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [SUB_W-1:0]          sub_a, sub_b;
    logic [SUB_W:0]            sub_diff;
    logic                      sub_ge;
    logic [SUB_W-1:0]          rem_sh;
    logic [SQ_W-1:0]           sq_final;
    logic [SUM_W:0]            sum_wide;
    logic [SUM_W-1:0]          sum_sat;
    logic [COUNT_W-1:0]        count_inc;
    logic signed [SHIFT_W-1:0] shifted;
    logic signed [TOTAL_W-1:0] total;
    logic                      sat_hi, sat_lo;
    logic [VALUE_W-1:0]        value_calc;

    assign cfg.ready = 1'b1;

    // Differences against the previous sample
    assign new_dx = DIFF_W'($signed(sample.accel_x)) - DIFF_W'($signed(ref_x_reg));
    assign new_dy = DIFF_W'($signed(sample.accel_y)) - DIFF_W'($signed(ref_y_reg));
    assign new_dz = DIFF_W'($signed(sample.accel_z)) - DIFF_W'($signed(ref_z_reg));

    // Select the axis to square; the last step squares nothing
    always_comb
    begin
        case (ctrl.step[1:0])
            2'd0:    sq_sel = dx_reg;
            2'd1:    sq_sel = dy_reg;
            2'd2:    sq_sel = dz_reg;
            default: sq_sel = '0;
        endcase
    end

    // Shared multiplier: squares, then mean times gain
    always_comb
    begin
        if (ctrl.op == OP_MUL)
        begin
            mul_a = $signed({1'b0, q_reg});
            mul_b = $signed(gain_reg);
        end
        else
        begin
            mul_a = MUL_A_W'(sq_sel);
            mul_b = MUL_B_W'(sq_sel);
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign sq_final = sq_reg + prod_reg[SQ_W-1:0];

    // Shared compare-and-subtract unit: root digits and divide steps
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};

    always_comb
    begin
        if (ctrl.op == OP_DIV)
        begin
            sub_a = SUB_W'({drem_reg, q_reg[SUM_W-1]});
            sub_b = SUB_W'(count_reg);
        end
        else
        begin
            sub_a = rem_sh;
            sub_b = SUB_W'({root_reg, 2'b01});
        end
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = ~sub_diff[SUB_W];

    // Saturating accumulate and count advance
    assign sum_wide  = {1'b0, sum_reg} + (SUM_W + 1)'(root_reg);
    assign sum_sat   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign count_inc = count_reg + COUNT_W'(1);

    assign stat.window_open = open_reg;
    assign stat.count_zero  = (count_reg == '0);
    assign stat.limit_hit   = (count_inc > max_reg) || (count_inc == {COUNT_W{1'b1}});

    // Scale back, add offset, saturate
    assign shifted = prod_reg[PROD_W-1:FRACTION_BITS];
    assign total   = TOTAL_W'(shifted) + TOTAL_W'($signed(offset_reg));
    assign sat_hi  = ~total[TOTAL_W-1] & (|total[TOTAL_W-2:VALUE_W-1]);
    assign sat_lo  = total[TOTAL_W-1] & ~(&total[TOTAL_W-2:VALUE_W-1]);

    always_comb
    begin
        if (!ctrl.out_has_data)
            value_calc = '0;
        else if (sat_hi)
            value_calc = {1'b0, {(VALUE_W-1){1'b1}}};
        else if (sat_lo)
            value_calc = {1'b1, {(VALUE_W-1){1'b0}}};
        else
            value_calc = total[VALUE_W-1:0];
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= RESET_GAIN;
            offset_reg <= RESET_OFFSET;
            max_reg    <= RESET_MAX_SAMPLES;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_GAIN:        gain_reg   <= cfg.data[GAIN_W-1:0];
                CFG_OFFSET:      offset_reg <= cfg.data[OFFSET_W-1:0];
                CFG_MAX_SAMPLES: max_reg    <= cfg.data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            open_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.op == OP_LOAD_REF || ctrl.op == OP_LOAD_DIFF)
            begin
                ref_x_reg <= sample.accel_x;
                ref_y_reg <= sample.accel_y;
                ref_z_reg <= sample.accel_z;
            end
            if (ctrl.op == OP_LOAD_REF)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                open_reg  <= 1'b1;
            end
            else if (ctrl.op == OP_ACC)
            begin
                sum_reg   <= sum_sat;
                count_reg <= count_inc;
            end
            if (ctrl.out_load)
                open_reg <= 1'b0;
        end
    end

    // Iteration registers
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_LOAD_DIFF:
            begin
                dx_reg <= new_dx;
                dy_reg <= new_dy;
                dz_reg <= new_dz;
            end
            OP_SQUARE:
            begin
                prod_reg <= mul_p;
                if (ctrl.step == '0)
                    sq_reg <= '0;
                else
                    sq_reg <= sq_final;
                if (ctrl.step == STEP_W'(SQUARE_STEPS - 1))
                begin
                    rad_reg  <= RAD_W'(sq_final) << (2 * FRACTION_BITS);
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            OP_ROOT:
            begin
                rem_reg  <= sub_ge ? sub_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], sub_ge};
                rad_reg  <= rad_reg << 2;
            end
            OP_DIV_LOAD:
            begin
                q_reg    <= sum_reg;
                drem_reg <= '0;
            end
            OP_DIV:
            begin
                drem_reg <= sub_ge ? sub_diff[COUNT_W-1:0] : sub_a[COUNT_W-1:0];
                q_reg    <= {q_reg[SUM_W-2:0], sub_ge};
            end
            OP_MUL:
                prod_reg <= mul_p;
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            value_reg     <= value_calc;
            out_count_reg <= count_reg;
            out_has_reg   <= ctrl.out_has_data;
            out_limit_reg <= ctrl.out_limit;
        end
    end

    assign motion_value    = value_reg;
    assign sample_count    = out_count_reg;
    assign has_data        = out_has_reg;
    assign closed_by_limit = out_limit_reg;

endmodule

// File: design/mmwa_seq.sv
module mmwa_seq import mmwa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sample_valid,
    input  logic [FUNC_W-1:0] sample_func,
    output logic     sample_ready,
    output logic     result_valid,
    input  logic     result_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              has_reg, has_next;
    logic              limit_reg, limit_next;
    logic              out_valid_reg, out_valid_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            has_reg       <= 1'b0;
            limit_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            has_reg       <= has_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        has_next          = has_reg;
        limit_next        = limit_reg;
        out_valid_next    = out_valid_reg;
        sample_ready      = 1'b0;
        ctrl.op           = OP_NONE;
        ctrl.step         = step_reg;
        ctrl.out_load     = 1'b0;
        ctrl.out_has_data = has_reg;
        ctrl.out_limit    = limit_reg;

        // Drop the result once taken
        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    if (sample_func == FUNC_REF)
                        ctrl.op = OP_LOAD_REF;
                    else if (sample_func == FUNC_ACC && stat.window_open)
                    begin
                        ctrl.op    = OP_LOAD_DIFF;
                        step_next  = '0;
                        state_next = ST_SQUARE;
                    end
                    else if (sample_func == FUNC_TICK && stat.window_open)
                    begin
                        limit_next = 1'b0;
                        has_next   = ~stat.count_zero;
                        state_next = stat.count_zero ? ST_OUT : ST_DIV_LOAD;
                    end
                end
            end
            ST_SQUARE:
            begin
                ctrl.op = OP_SQUARE;
                if (step_reg == STEP_W'(SQUARE_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_ROOT:
            begin
                ctrl.op = OP_ROOT;
                if (step_reg == STEP_W'(ROOT_W - 1))
                    state_next = ST_ACC;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_ACC:
            begin
                ctrl.op = OP_ACC;
                if (stat.limit_hit)
                begin
                    limit_next = 1'b1;
                    has_next   = 1'b1;
                    state_next = ST_DIV_LOAD;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DIV_LOAD:
            begin
                ctrl.op    = OP_DIV_LOAD;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                ctrl.op = OP_DIV;
                if (step_reg == STEP_W'(SUM_W - 1))
                    state_next = ST_MUL;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_MUL:
            begin
                ctrl.op    = OP_MUL;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || result_ready)
                begin
                    ctrl.out_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

// File: design/motion_magnitude_window_averager_core.sv
// Channel   Role    Payload
// sample    sink    func, accel_x, accel_y, accel_z
// result    source  motion_value, sample_count, has_data, closed_by_limit
// cfg       sink    index (0 gain, 1 offset, 2 max_samples), data
//
// Reference, tick on a closed window and unused codes are handled in the idle state.
// Accumulate sample: 4 square steps on the shared multiplier, 22 root digits on
// the shared subtract unit, 1 accumulate; a close adds 32 divide steps on the same
// subtract unit, a multiply and the output. An empty window goes straight to output.
// Reset is asynchronous: configuration registers return to defaults and no window is open.
// A waiting result does not block the next request; only a new close waits.
module motion_magnitude_window_averager_core import mmwa_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    mmwa_sample_if.sink  sample,
    mmwa_result_if.source result,
    mmwa_cfg_if.sink     cfg
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    mmwa_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_func  (sample.func),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .ctrl         (ctrl)
    );

    mmwa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample          (sample),
        .cfg             (cfg),
        .ctrl            (ctrl),
        .stat            (stat),
        .motion_value    (result.motion_value),
        .sample_count    (result.sample_count),
        .has_data        (result.has_data),
        .closed_by_limit (result.closed_by_limit)
    );

endmodule

// File: design/mmwa_checker.sv
module mmwa_checker import mmwa_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               sample_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic [VALUE_W-1:0] motion_value,
    input logic [COUNT_W-1:0] sample_count,
    input logic               has_data,
    input logic               closed_by_limit
);

    // Hold a pending result until taken
    property p_valid_hold;
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid;
    endproperty
    a_valid_hold: assert property (p_valid_hold)
        else $error("result valid dropped while stalled");

    // An empty window reports all zero
    property p_empty;
        @(posedge clk) disable iff (!rst_n)
        result_valid && !has_data |->
            motion_value == '0 && sample_count == '0 && !closed_by_limit;
    endproperty
    a_empty: assert property (p_empty)
        else $error("empty window result not cleared");

    // A limit close always carries samples
    property p_limit_data;
        @(posedge clk) disable iff (!rst_n)
        result_valid && closed_by_limit |-> has_data && sample_count != '0;
    endproperty
    a_limit_data: assert property (p_limit_data)
        else $error("limit close without samples");

    // A new result follows busy cycles
    property p_rise_busy;
        @(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(sample_ready);
    endproperty
    a_rise_busy: assert property (p_rise_busy)
        else $error("result appeared without processing");

endmodule

bind motion_magnitude_window_averager_core mmwa_checker u_mmwa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .sample_ready    (sample.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .motion_value    (result.motion_value),
    .sample_count    (result.sample_count),
    .has_data        (result.has_data),
    .closed_by_limit (result.closed_by_limit)
);

// File: verif/tb.sv
module tb;
    import mmwa_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int CLK_HALF       = 10;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 600;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int REPORT_LIMIT   = 10;
    localparam longint VALUE_MAX  = 64'sd2147483647;
    localparam longint VALUE_MIN  = -64'sd2147483648;

    typedef struct packed {
        logic [VALUE_W-1:0] motion_value;
        logic [COUNT_W-1:0] sample_count;
        logic               has_data;
        logic               closed_by_limit;
    } window_result_t;

    // Tracks the open window and the register file, and queues each window close
    class window_average_model;
        logic signed [AXIS_BITS-1:0] prev_x, prev_y, prev_z;
        logic [SUM_W-1:0]            mag_sum;
        logic [COUNT_W-1:0]          count;
        logic                        win_open;
        logic signed [GAIN_W-1:0]    gain;
        logic signed [OFFSET_W-1:0]  offset;
        logic [COUNT_W-1:0]          max_samples;
        window_result_t              pending[$];
        int mismatches, checked, limit_closes, empty_windows, samples;

        function new();
            prev_x = '0;
            prev_y = '0;
            prev_z = '0;
            mag_sum = '0;
            count = '0;
            win_open = 1'b0;
            gain = RESET_GAIN;
            offset = RESET_OFFSET;
            max_samples = RESET_MAX_SAMPLES;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_GAIN:        gain = d[GAIN_W-1:0];
                CFG_OFFSET:      offset = d[OFFSET_W-1:0];
                CFG_MAX_SAMPLES: max_samples = d[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Mean times gain, floor shift, add offset, clamp to 32 bits
        function void close_window(bit by_limit);
            window_result_t r;
            longint mean_v, scaled;
            r = '0;
            r.sample_count = count;
            r.closed_by_limit = by_limit;
            if (count != 0) begin
                r.has_data = 1'b1;
                mean_v = longint'(mag_sum / count);
                scaled = (mean_v * longint'(gain)) >>> FRACTION_BITS;
                scaled = scaled + longint'(offset);
                if (scaled > VALUE_MAX)
                    scaled = VALUE_MAX;
                if (scaled < VALUE_MIN)
                    scaled = VALUE_MIN;
                r.motion_value = scaled[VALUE_W-1:0];
            end
            else
                empty_windows++;
            if (by_limit)
                limit_closes++;
            pending.push_back(r);
            win_open = 1'b0;
        endfunction

        function void take_sample(logic [FUNC_W-1:0] f, logic [AXIS_BITS-1:0] x,
                                  logic [AXIS_BITS-1:0] y, logic [AXIS_BITS-1:0] z);
            int dx, dy, dz;
            longint unsigned radicand, root, total;
            samples++;
            if (f == FUNC_REF) begin
                prev_x = x;
                prev_y = y;
                prev_z = z;
                mag_sum = '0;
                count = '0;
                win_open = 1'b1;
            end
            else if (f == FUNC_TICK) begin
                if (win_open)
                    close_window(1'b0);
            end
            else if (f == FUNC_ACC && win_open) begin
                dx = $signed(x) - prev_x;
                dy = $signed(y) - prev_y;
                dz = $signed(z) - prev_z;
                radicand = longint'(dx * dx + dy * dy + dz * dz) << (2 * FRACTION_BITS);
                // Build the truncated root one bit at a time from the top
                root = 0;
                for (int b = 31; b >= 0; b--) begin
                    total = root | (64'd1 << b);
                    if (total * total <= radicand)
                        root = total;
                end
                total = mag_sum + root;
                mag_sum = (total > 64'hFFFF_FFFF) ? '1 : total[SUM_W-1:0];
                prev_x = x;
                prev_y = y;
                prev_z = z;
                count = count + 1'b1;
                if (count > max_samples || count == 8'hFF)
                    close_window(1'b1);
            end
        endfunction

        function void check_result(window_result_t got);
            window_result_t want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected window result: value %h count %0d has_data %b limit %b",
                             got.motion_value, got.sample_count, got.has_data,
                             got.closed_by_limit);
            end
            else begin
                want = pending.pop_front();
                if (got.motion_value !== want.motion_value
                    || got.sample_count !== want.sample_count
                    || got.has_data !== want.has_data
                    || got.closed_by_limit !== want.closed_by_limit) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("exp/act %0d: value %h/%h cnt %0d/%0d has %b/%b lim %b/%b",
                                 checked, want.motion_value, got.motion_value,
                                 want.sample_count, got.sample_count,
                                 want.has_data, got.has_data,
                                 want.closed_by_limit, got.closed_by_limit);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   hold_start = 1'b0;
    bit   rx_hold = 1'b0;
    int   tx_idle_pct = 13;
    int   rx_idle_pct = 52;
    int   items_sent = 0;
    int   settings_used = 0;
    logic [AXIS_BITS-1:0] gen_x = '0, gen_y = '0, gen_z = '0;
    window_average_model model;

    mmwa_sample_if sample_bus ();
    mmwa_result_if result_bus ();
    mmwa_cfg_if    cfg_bus ();

    motion_magnitude_window_averager_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Pick the idle pattern for both sides from how far the run has come
    task automatic send_sample(logic [FUNC_W-1:0] f, logic [AXIS_BITS-1:0] x,
                               logic [AXIS_BITS-1:0] y, logic [AXIS_BITS-1:0] z);
        tx_idle_pct = (items_sent < 300) ? 13 : (items_sent < 600) ? 52 : 0;
        rx_idle_pct = (items_sent < 300) ? 52 : (items_sent < 600) ? 13 : 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid   <= 1'b1;
        sample_bus.func    <= f;
        sample_bus.accel_x <= x;
        sample_bus.accel_y <= y;
        sample_bus.accel_z <= z;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        model.take_sample(f, x, y, z);
        items_sent++;
    endtask

    // Mix of rail values, full-range jumps and a slow walk
    function automatic logic [AXIS_BITS-1:0] next_axis(logic [AXIS_BITS-1:0] cur);
        case ($urandom_range(9)) inside
            0:       return 13'h1000;
            1:       return 13'h0FFF;
            [2:3]:   return AXIS_BITS'($urandom);
            default: return cur + AXIS_BITS'($urandom_range(64)) - 13'd32;
        endcase
    endfunction

    task automatic send_random(logic [FUNC_W-1:0] f);
        gen_x = next_axis(gen_x);
        gen_y = next_axis(gen_y);
        gen_z = next_axis(gen_z);
        send_sample(f, gen_x, gen_y, gen_z);
    endtask

    // Hold the sender until every window has come out, then let the core settle
    task automatic wait_idle();
        sample_bus.valid <= 1'b0;
        while (model.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(logic [CFG_DATA_W-1:0] g, logic [CFG_DATA_W-1:0] o,
                                logic [CFG_DATA_W-1:0] m);
        logic [CFG_DATA_W-1:0] vals [3];
        cfg_idx_t idx;
        vals = '{g, o, m};
        for (int i = 0; i < 3; i++) begin
            idx = cfg_idx_t'(i);
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx;
            cfg_bus.data  <= vals[i];
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
            model.write_reg(idx, vals[i]);
        end
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly whole windows with random content, some stray requests between them
    task automatic run_windows(int budget, int max_len);
        int n, len;
        n = 0;
        while (n < budget) begin
            if ($urandom_range(99) < 15)
                send_random(FUNC_W'($urandom_range(3)));
            else begin
                send_random(FUNC_REF);
                len = $urandom_range(max_len);
                repeat (len) send_random(FUNC_ACC);
                if ($urandom_range(99) < 85)
                    send_random(FUNC_TICK);
                n += len + 2;
            end
        end
    endtask

    // Accept and check results; ready follows the idle pattern and the hold-off
    initial begin
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
                model.check_result({result_bus.motion_value, result_bus.sample_count,
                                    result_bus.has_data, result_bus.closed_by_limit});
            result_bus.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver stall so that closed windows back up into the input
    initial begin
        wait (hold_start);
        @(negedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
    end

    initial begin
        #(64'd2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [CFG_DATA_W-1:0] gains [6];
        logic [CFG_DATA_W-1:0] offsets [6];
        logic [CFG_DATA_W-1:0] limits [6];
        int spans [6];

        model = new();
        rst_n <= 1'b0;
        sample_bus.valid   <= 1'b0;
        sample_bus.func    <= FUNC_REF;
        sample_bus.accel_x <= '0;
        sample_bus.accel_y <= '0;
        sample_bus.accel_z <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= CFG_GAIN;
        cfg_bus.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Stray requests with no window open, then rail-to-rail swing and a repeat
        send_sample(FUNC_TICK, 13'h0000, 13'h0000, 13'h0000);
        send_sample(FUNC_ACC, 13'h0FFF, 13'h1000, 13'h0FFF);
        send_sample(FUNC_SPARE, 13'h1FFF, 13'h1FFF, 13'h1FFF);
        send_sample(FUNC_REF, 13'h1000, 13'h1000, 13'h1000);
        send_sample(FUNC_ACC, 13'h0FFF, 13'h0FFF, 13'h0FFF);
        send_sample(FUNC_ACC, 13'h0FFF, 13'h0FFF, 13'h0FFF);
        send_sample(FUNC_SPARE, 13'h0000, 13'h0000, 13'h0000);
        send_sample(FUNC_TICK, 13'h0000, 13'h0000, 13'h0000);
        send_sample(FUNC_TICK, 13'h0000, 13'h0000, 13'h0000);
        // Empty window, then a reference that drops an open window
        send_sample(FUNC_REF, 13'h0000, 13'h0000, 13'h0000);
        send_sample(FUNC_TICK, 13'h0000, 13'h0000, 13'h0000);
        send_sample(FUNC_REF, 13'd5, -13'sd3, 13'd7);
        send_sample(FUNC_ACC, 13'd100, 13'h0000, 13'h0000);
        send_sample(FUNC_REF, 13'h0000, 13'h0000, 13'h0000);
        send_sample(FUNC_ACC, 13'h0000, 13'h0000, 13'h0FFF);
        send_sample(FUNC_TICK, 13'h0000, 13'h0000, 13'h0000);

        // Most negative gain and offset, limit one: clamp low
        wait_idle();
        program_regs(32'hFF80_0000, 32'h8000_0000, 32'd1);
        send_sample(FUNC_REF, 13'h1000, 13'h1000, 13'h1000);
        send_sample(FUNC_ACC, 13'h0FFF, 13'h0FFF, 13'h0FFF);
        send_sample(FUNC_ACC, 13'h1000, 13'h1000, 13'h1000);

        // Most positive gain and offset, limit zero: clamp high, later sample dropped
        wait_idle();
        program_regs(32'h007F_FFFF, 32'h7FFF_FFFF, 32'd0);
        send_sample(FUNC_REF, 13'h0FFF, 13'h1000, 13'h0FFF);
        send_sample(FUNC_ACC, 13'h1000, 13'h0FFF, 13'h1000);
        send_sample(FUNC_ACC, 13'h0000, 13'h0000, 13'h0000);

        gains   = '{32'h0001_0000, $urandom, 32'h007F_FFFF, 32'hFF80_0000, $urandom, $urandom};
        offsets = '{32'h0000_0000, $urandom, 32'h7FFF_FFFF, 32'h8000_0000, $urandom, $urandom};
        limits  = '{32'd8, $urandom_range(1, 30), 32'd0, 32'd255, 32'd3, $urandom_range(1, 254)};
        spans   = '{12, 40, 4, 10, 6, 20};

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            program_regs(gains[p], offsets[p], limits[p]);
            // Full counter: one window long enough to reach the count ceiling and close by limit
            if (limits[p][COUNT_W-1:0] == 8'hFF) begin
                send_random(FUNC_REF);
                repeat (260) send_random(FUNC_ACC);
                send_random(FUNC_TICK);
            end
            if (p == 4)
                hold_start = 1'b1;
            run_windows(90, spans[p]);
        end

        wait_idle();
        $display("Ran %0d requests through %0d register settings with idle, stall and hold-off.",
                 model.samples, settings_used);
        $display("Checked %0d windows: %0d closed by limit, %0d empty.",
                 model.checked, model.limit_closes, model.empty_windows);
        if (model.mismatches == 0 && model.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
